/* rtl/stq_pkg.sv */
// ---------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Widths, command and status codes, and the control and status bundles
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  // field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 4;
  localparam int IN_TIME_W = 48;
  localparam int ST_W      = 2;

  // queue geometry
  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 48;
  localparam int NUM_IDS   = 1 << ID_W;
  localparam int QCAP      = (CAPACITY < NUM_IDS) ? CAPACITY : NUM_IDS;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_ADJUST = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  // result kinds
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  // datapath operations
  typedef enum logic [1:0] {
    DP_NONE   = 2'd0,
    DP_INSERT = 2'd1,
    DP_REMOVE = 2'd2,
    DP_POP    = 2'd3
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic            id_queued;
    logic            full;
    logic            head_expired;
    logic            next_expired;
    logic [ID_W-1:0] head_id;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/stq_datapath.sv */
// ---------------------------------------------------------------------------
// stq_datapath: sorted slot array of the timer queue
// Holds the slots in expiry order with an occupancy count and a mask of
// queued ids. Each slot compares itself to the operand in parallel, so a
// sorted insert, a removal by id or a head pop each updates all slots together.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_datapath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  stq_pkg::dp_ctrl_t                   ctrl,
  input  wire  [stq_pkg::ID_W-1:0]            in_timer_id,
  input  wire  [stq_pkg::IN_TIME_W-1:0]       in_time_value,
  output stq_pkg::dp_stat_t                   stat
);

  localparam int CAP = stq_pkg::CAPACITY;

  // slot storage, only slots below the count hold live timers
  logic [stq_pkg::ID_W-1:0]      slot_id_r  [CAP];
  logic [stq_pkg::TIME_BITS-1:0] slot_exp_r [CAP];
  logic [stq_pkg::ID_W-1:0]      slot_id_nxt  [CAP];
  logic [stq_pkg::TIME_BITS-1:0] slot_exp_nxt [CAP];
  logic [stq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [stq_pkg::NUM_IDS-1:0]   mask_r, mask_nxt;

  // operand latched with the beat
  logic [stq_pkg::ID_W-1:0]      id_r;
  logic [stq_pkg::TIME_BITS-1:0] time_r;

  logic [CAP-1:0] occ;
  logic [CAP-1:0] le;
  logic [CAP-1:0] hit;
  logic [CAP-1:0] after;
  logic           any_hit;
  logic [stq_pkg::ID_W-1:0] rm_id;

  // per-slot compares
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int k = 0; k < CAP; k++) begin
      occ[k] = stq_pkg::CNT_W'(k) < count_r;
      le[k]  = occ[k] && (slot_exp_r[k] <= time_r);
      if (ctrl.op == stq_pkg::DP_POP) begin
        hit[k] = (k == 0) && occ[k];
      end else begin
        hit[k] = occ[k] && (slot_id_r[k] == id_r);
      end
      acc      = acc | hit[k];
      after[k] = acc;
    end
    any_hit = acc;
    rm_id   = (ctrl.op == stq_pkg::DP_POP) ? slot_id_r[0] : id_r;
  end

  // next slot contents
  always_comb begin
    count_nxt = count_r;
    mask_nxt  = mask_r;
    for (int k = 0; k < CAP; k++) begin
      slot_id_nxt[k]  = slot_id_r[k];
      slot_exp_nxt[k] = slot_exp_r[k];
    end
    case (ctrl.op)
      stq_pkg::DP_INSERT: begin
        for (int k = 0; k < CAP; k++) begin
          if (!le[k]) begin
            if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
              slot_id_nxt[k]  = id_r;
              slot_exp_nxt[k] = time_r;
            end else begin
              slot_id_nxt[k]  = slot_id_r[(k == 0) ? 0 : k - 1];
              slot_exp_nxt[k] = slot_exp_r[(k == 0) ? 0 : k - 1];
            end
          end
        end
        count_nxt     = count_r + 1'b1;
        mask_nxt[id_r] = 1'b1;
      end
      stq_pkg::DP_REMOVE, stq_pkg::DP_POP: begin
        for (int k = 0; k < CAP - 1; k++) begin
          if (after[k]) begin
            slot_id_nxt[k]  = slot_id_r[k + 1];
            slot_exp_nxt[k] = slot_exp_r[k + 1];
          end
        end
        if (any_hit) begin
          count_nxt = count_r - 1'b1;
        end
        mask_nxt[rm_id] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mask_r  <= '0;
    end else begin
      count_r <= count_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < CAP; k++) begin
      slot_id_r[k]  <= slot_id_nxt[k];
      slot_exp_r[k] <= slot_exp_nxt[k];
    end
    if (ctrl.load) begin
      id_r   <= in_timer_id;
      time_r <= in_time_value[stq_pkg::TIME_BITS-1:0];
    end
  end

  // status towards the controller
  assign stat.id_queued    = mask_r[id_r];
  assign stat.full         = count_r >= stq_pkg::CNT_W'(stq_pkg::QCAP);
  assign stat.head_expired = le[0];
  assign stat.next_expired = le[1];
  assign stat.head_id      = slot_id_r[0];

endmodule

`default_nettype wire

/* rtl/stq_controller.sv */
// ---------------------------------------------------------------------------
// stq_controller: command sequencer and result register
// Takes one beat at a time, steps the datapath through delete, insert or
// pop, and holds each result in an output register until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_controller (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [stq_pkg::CMD_W-1:0]      in_command,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_kind,
  output logic [stq_pkg::ID_W-1:0]       out_expired_id,
  output logic [stq_pkg::ST_W-1:0]       out_status,
  output logic                           out_last,
  output stq_pkg::dp_ctrl_t              ctrl,
  input  stq_pkg::dp_stat_t              stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL,
    S_ADD,
    S_RESP,
    S_TICK
  } state_t;

  state_t                     state_r;
  stq_pkg::cmd_t              cmd_r;
  stq_pkg::status_t           st_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_kind_r;
  logic [stq_pkg::ID_W-1:0]   out_id_r;
  logic [stq_pkg::ST_W-1:0]   out_status_r;
  logic                       out_last_r;

  logic in_fire;
  logic out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // datapath commands
  always_comb begin
    ctrl.load = in_fire;
    ctrl.op   = stq_pkg::DP_NONE;
    case (state_r)
      S_DEL: begin
        if (stat.id_queued) begin
          ctrl.op = stq_pkg::DP_REMOVE;
        end
      end
      S_ADD: begin
        if (!stat.id_queued && !stat.full) begin
          ctrl.op = stq_pkg::DP_INSERT;
        end
      end
      S_TICK: begin
        if (stat.head_expired && out_free) begin
          ctrl.op = stq_pkg::DP_POP;
        end
      end
      default: begin
      end
    endcase
  end

  // result register occupancy: held while stalled, loaded by a new result
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_RESP && out_free) begin
      out_valid_nxt = 1'b1;
    end
    if (state_r == S_TICK && stat.head_expired && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= stq_pkg::cmd_t'(in_command);
            case (stq_pkg::cmd_t'(in_command))
              stq_pkg::CMD_ADD:  state_r <= S_ADD;
              stq_pkg::CMD_TICK: state_r <= S_TICK;
              default:           state_r <= S_DEL;
            endcase
          end
        end
        S_DEL: begin
          st_r    <= stat.id_queued ? stq_pkg::ST_OK : stq_pkg::ST_ABSENT;
          state_r <= (cmd_r == stq_pkg::CMD_DELETE) ? S_RESP : S_ADD;
        end
        S_ADD: begin
          if (stat.id_queued) begin
            st_r <= stq_pkg::ST_DUP;
          end else if (stat.full) begin
            st_r <= stq_pkg::ST_FULL;
          end else begin
            st_r <= stq_pkg::ST_OK;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_kind_r   <= stq_pkg::KIND_STATUS;
            out_id_r     <= '0;
            out_status_r <= st_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_TICK: begin
          if (!stat.head_expired) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_kind_r   <= stq_pkg::KIND_EXPIRED;
            out_id_r     <= stat.head_id;
            out_status_r <= stq_pkg::ST_OK;
            out_last_r   <= !stat.next_expired;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_expired_id = out_id_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/sorted_timer_queue_core.sv */
// ---------------------------------------------------------------------------
// sorted_timer_queue_core: timer queue kept in expiry order
// Usage:
//   Input beats (in_valid/in_stall) carry a command, a timer id and a time.
//   Add, delete and adjust each give one status beat on the result channel
//   (out_valid/out_stall) with out_last set. A tick gives one report beat
//   per expired timer, earliest first, the final one marked last, or no
//   beat at all when nothing has expired.
//   One beat is worked on at a time; in_stall is high until it is done.
//   Add and delete: one datapath step (S_ADD or S_DEL), then the result
//   step (S_RESP) loads the status beat, and the next input beat is
//   taken after it. Adjust: delete step, insert step, result step.
//   A tick: the head slot is popped and reported, one per cycle while
//   the output register is free, until the head has not expired; the
//   sequencer then returns to idle and takes the next input beat.
//   Results sit in a single output register; while out_stall holds a
//   beat, the sequencer waits at its next result with in_stall high.
//   Reset (rst_n low, synchronous) empties the queue at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [stq_pkg::CMD_W-1:0]       in_command,
  input  wire  [stq_pkg::ID_W-1:0]        in_timer_id,
  input  wire  [stq_pkg::IN_TIME_W-1:0]   in_time_value,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_kind,
  output logic [stq_pkg::ID_W-1:0]        out_expired_id,
  output logic [stq_pkg::ST_W-1:0]        out_status,
  output logic                            out_last
);

  stq_pkg::dp_ctrl_t ctrl;
  stq_pkg::dp_stat_t stat;

  // sequencer and result register
  stq_controller u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_expired_id (out_expired_id),
    .out_status     (out_status),
    .out_last       (out_last),
    .ctrl           (ctrl),
    .stat           (stat)
  );

  // sorted slot array
  stq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_timer_id   (in_timer_id),
    .in_time_value (in_time_value),
    .stat          (stat)
  );

endmodule

`default_nettype wire
